[rtl/wsfd_pkg.sv]
// shared types and codes for the websocket frame decoder
`default_nettype none

package wsfd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // error codes, named after the stage that was cut short
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_HDR     = 3'd1;
    localparam logic [2:0] ERR_EXT     = 3'd2;
    localparam logic [2:0] ERR_KEY     = 3'd3;
    localparam logic [2:0] ERR_PAYLOAD = 3'd4;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QAW      = 2;
    localparam int unsigned QCW      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        fin_flag;
        logic [3:0]  op_code;
        logic        mask_flag;
        logic [63:0] payload_length;
        logic [7:0]  data_out;
        logic        last_of_frame;
        logic [2:0]  error_code;
    } t_result;

endpackage

`default_nettype wire

[rtl/wsfd_parser.sv]
// header parser and payload unmasker, one byte per accepted transaction
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    output t_result         o_res0,
    output t_result         o_res1,
    output logic [1:0]      o_cnt
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LEN  = 3'd1,
        ST_EXT  = 3'd2,
        ST_KEY  = 3'd3,
        ST_PAY  = 3'd4
    } t_stage;

    t_stage      r_stage, n_stage;
    logic        r_fin, n_fin;
    logic [3:0]  r_op, n_op;
    logic        r_mask, n_mask;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_hbc, n_hbc;
    logic [31:0] r_key, n_key;
    logic [63:0] r_rem, n_rem;
    logic [1:0]  r_kp, n_kp;

    logic [1:0]  n_cnt;
    logic [1:0]  k0;
    logic [7:0]  d0;
    logic        l0;
    logic [2:0]  e0;
    logic [7:0]  kb;
    logic        after_len;
    logic        hdr_done;

    always_comb begin
        n_stage   = r_stage;
        n_fin     = r_fin;
        n_op      = r_op;
        n_mask    = r_mask;
        n_len     = r_len;
        n_hbc     = r_hbc;
        n_key     = r_key;
        n_rem     = r_rem;
        n_kp      = r_kp;
        n_cnt     = 2'd0;
        k0        = KIND_HDR;
        d0        = 8'd0;
        l0        = 1'b0;
        e0        = ERR_NONE;
        kb        = 8'd0;
        after_len = 1'b0;
        hdr_done  = 1'b0;

        case (r_stage)
            ST_LEN: begin
                n_mask = i_byte[7];
                if (i_byte[6:0] == LEN_EXT16 || i_byte[6:0] == LEN_EXT64) begin
                    n_len   = 64'd0;
                    n_hbc   = (i_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                    n_stage = ST_EXT;
                    if (i_end) begin
                        n_stage = ST_IDLE;
                        n_cnt   = 2'd1;
                        k0      = KIND_ERR;
                        e0      = ERR_EXT;
                    end
                end else begin
                    n_len     = 64'(i_byte[6:0]);
                    after_len = 1'b1;
                end
            end
            ST_EXT: begin
                n_len = {r_len[55:0], i_byte};
                n_hbc = r_hbc - 4'd1;
                if (n_hbc == 4'd0) begin
                    after_len = 1'b1;
                end else if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd1;
                    k0      = KIND_ERR;
                    e0      = ERR_EXT;
                end
            end
            ST_KEY: begin
                n_key = {r_key[23:0], i_byte};
                n_hbc = r_hbc - 4'd1;
                if (n_hbc == 4'd0) begin
                    hdr_done = 1'b1;
                end else if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd1;
                    k0      = KIND_ERR;
                    e0      = ERR_KEY;
                end
            end
            ST_PAY: begin
                // first key byte sits in the top bits
                kb    = r_mask ? r_key[{~r_kp, 3'b000} +: 8] : 8'd0;
                d0    = i_byte ^ kb;
                n_kp  = r_kp + 2'd1;
                n_rem = r_rem - 64'd1;
                k0    = KIND_PAY;
                n_cnt = 2'd1;
                if (n_rem == 64'd0) begin
                    n_stage = ST_IDLE;
                    l0      = 1'b1;
                end else if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd2;
                end
            end
            default: begin
                n_fin   = i_byte[7];
                n_op    = i_byte[3:0];
                n_mask  = 1'b0;
                n_len   = 64'd0;
                n_key   = 32'd0;
                n_hbc   = 4'd0;
                n_rem   = 64'd0;
                n_kp    = 2'd0;
                n_stage = ST_LEN;
                if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd1;
                    k0      = KIND_ERR;
                    e0      = ERR_HDR;
                end
            end
        endcase

        if (after_len) begin
            if (n_mask) begin
                n_stage = ST_KEY;
                n_hbc   = 4'd4;
                if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd1;
                    k0      = KIND_ERR;
                    e0      = ERR_KEY;
                end
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_rem = n_len;
            n_kp  = 2'd0;
            n_cnt = 2'd1;
            k0    = KIND_HDR;
            if (n_len == 64'd0) begin
                n_stage = ST_IDLE;
                l0      = 1'b1;
            end else begin
                n_stage = ST_PAY;
                if (i_end) begin
                    n_stage = ST_IDLE;
                    n_cnt   = 2'd2;
                end
            end
        end
    end

    always_comb begin
        o_cnt                 = i_valid ? n_cnt : 2'd0;
        o_res0.kind           = k0;
        o_res0.fin_flag       = n_fin;
        o_res0.op_code        = n_op;
        o_res0.mask_flag      = n_mask;
        o_res0.payload_length = n_len;
        o_res0.data_out       = d0;
        o_res0.last_of_frame  = l0;
        o_res0.error_code     = e0;
        // a second result is only ever the payload-incomplete error
        o_res1                = o_res0;
        o_res1.kind           = KIND_ERR;
        o_res1.data_out       = 8'd0;
        o_res1.last_of_frame  = 1'b0;
        o_res1.error_code     = ERR_PAYLOAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            r_fin   <= 1'b0;
            r_op    <= 4'd0;
            r_mask  <= 1'b0;
            r_len   <= 64'd0;
            r_hbc   <= 4'd0;
            r_key   <= 32'd0;
            r_rem   <= 64'd0;
            r_kp    <= 2'd0;
        end else if (i_valid) begin
            r_stage <= n_stage;
            r_fin   <= n_fin;
            r_op    <= n_op;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_hbc   <= n_hbc;
            r_key   <= n_key;
            r_rem   <= n_rem;
            r_kp    <= n_kp;
        end
    end

    a_pay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == ST_PAY |-> r_rem != 64'd0)
        else $error("payload stage with nothing left to receive");

    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cnt != 2'd0 && o_res0.kind == KIND_ERR) |-> !o_res0.last_of_frame)
        else $error("error result marked as end of frame");

    a_two_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cnt == 2'd2 |=> r_stage == ST_IDLE)
        else $error("parser not idle after an incomplete-payload error");

endmodule

`default_nettype wire

[rtl/wsfd_out_queue.sv]
// small result queue: takes up to two results per cycle, hands out one
`default_nettype none

module wsfd_out_queue
    import wsfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  wire t_result    i_d0,
    input  wire t_result    i_d1,
    output logic            o_space,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_data
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid & i_ready;
    // room for the worst case of two results from the next byte
    assign o_space = (r_count <= QCW'(QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + QAW'(1)] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QAW'(i_push_n);
            r_rp    <= r_rp + QAW'(pop);
            r_count <= r_count + QCW'(i_push_n) - QCW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd0 |-> r_count <= QCW'(QDEPTH - 2))
        else $error("push into a queue without room");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd0 && !pop) |=> $stable(r_count))
        else $error("queue count moved with no push or pop");

endmodule

`default_nettype wire

[rtl/websocket_frame_decoder.sv]
// websocket frame decoder top level: byte stream in, header/payload/error results out
// each result is written into a four-entry output queue as its byte is accepted
// throughput: one byte per cycle while s_axis_tready is high; a byte can yield two
// results (the second being the payload-incomplete error), which drain one per cycle
// while m_axis_tready is high; s_axis_tready drops while the queue holds over two
// reset: synchronous active-low i_rst_n returns the parser to idle and empties the queue
`default_nettype none

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // buffer_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] fin_flag, [4:1] op_code, [5] mask_flag, [69:6] payload_length,
    // [77:70] data_out, [80:78] error_code, [87:81] zero
    output logic [87:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last_of_frame
);

    logic       accept;
    logic       space;
    logic [1:0] res_cnt;
    t_result    res0;
    t_result    res1;
    t_result    head;

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = space;

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_cnt   (res_cnt)
    );

    wsfd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (res_cnt),
        .i_d0     (res0),
        .i_d1     (res1),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (head)
    );

    assign m_axis_tdata = {7'd0, head.error_code, head.data_out, head.payload_length,
                           head.mask_flag, head.op_code, head.fin_flag};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_frame;

endmodule

`default_nettype wire
